// ----- sv/rdsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types for the reply delay search controller
// Search phases, decision codes, register indexes and the configuration and
// result bundles passed between the controller modules.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  typedef enum logic [1:0] {
    PH_EXP  = 2'd0,
    PH_BIN  = 2'd1,
    PH_HOLD = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    DEC_VERIFIED    = 4'd0,
    DEC_HOLD_MIN    = 4'd1,
    DEC_EXP_LOWER   = 4'd2,
    DEC_HOLD_BEST   = 4'd3,
    DEC_BIN_LOWER   = 4'd4,
    DEC_RETRY_MAX   = 4'd5,
    DEC_BIN_START   = 4'd6,
    DEC_BIN_RAISE   = 4'd7,
    DEC_BACKOFF     = 4'd8,
    DEC_HOLD_MAX    = 4'd9,
    DEC_NONE        = 4'd10
  } dec_t;

  typedef enum logic [2:0] {
    REG_LONGEST  = 3'd0,
    REG_SHORTEST = 3'd1,
    REG_STEP     = 3'd2,
    REG_LARGEST  = 3'd3,
    REG_JUMP     = 3'd4,
    REG_TESTS    = 3'd5,
    REG_REQUIRED = 3'd6
  } cfg_reg_t;

  localparam logic [14:0] STEP_DOUBLE_LIMIT = 15'h7FFF;

  typedef struct packed {
    logic [15:0] longest_delay_us;
    logic [15:0] shortest_delay_us;
    logic [15:0] delay_step_us;
    logic [7:0]  largest_index;
    logic [15:0] initial_jump;
    logic [7:0]  tests_per_window;
    logic [7:0]  success_quota;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  next_index;
    logic [15:0] next_delay_us;
    phase_t      search_phase;
    logic        window_done;
    dec_t        decision;
    logic        found_reliable;
    logic [7:0]  best_index;
    logic [15:0] best_delay_us;
  } result_t;

  // A zero jump still has to move the search.
  function automatic logic [15:0] first_jump(input logic [15:0] jump);
    first_jump = (jump == 16'd0) ? 16'd1 : jump;
  endfunction

endpackage

// ----- sv/rdsc_delay_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_delay_calc: index to reply delay
// Clamp the index to the largest index, scale by the step, subtract from the
// longest delay (floor at zero) and raise to the shortest delay.
// ----------------------------------------------------------------------------
module rdsc_delay_calc (
  input  rdsc_pkg::cfg_t cfg,
  input  logic [7:0]     index,
  output logic [15:0]    delay_us
);

  logic [7:0]  clamped;
  logic [23:0] cut;
  logic [15:0] reduced;

  always_comb begin
    clamped  = (index < cfg.largest_index) ? index : cfg.largest_index;
    cut      = {16'd0, clamped} * {8'd0, cfg.delay_step_us};
    reduced  = (cut > {8'd0, cfg.longest_delay_us}) ? 16'd0
             : (cfg.longest_delay_us - cut[15:0]);
    delay_us = (reduced < cfg.shortest_delay_us) ? cfg.shortest_delay_us : reduced;
  end

endmodule

// ----- sv/rdsc_search_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_search_core: window counting and search state
// Count the window, judge it when full, choose the next index and keep the
// search state. Also refresh the delay of the current index every idle cycle.
// ----------------------------------------------------------------------------
module rdsc_search_core (
  input  logic              clk,
  input  logic              rst,
  input  rdsc_pkg::cfg_t    cfg,
  input  logic              jump_load,
  input  logic [15:0]       jump_value,
  input  logic              step,
  input  logic              ok,
  output rdsc_pkg::result_t result
);

  rdsc_pkg::phase_t phase_reg, phase_next;
  logic [7:0]  current_index;
  logic [7:0]  window_attempts;
  logic [7:0]  window_successes;
  logic        have_reliable;
  logic [7:0]  best_index_reg;
  logic [15:0] best_delay_reg;
  logic [15:0] first_failed;
  logic [15:0] jump_step;
  logic [15:0] cur_delay;

  logic [7:0]  wa_inc, ws_inc;
  logic        done, reliable;
  logic [8:0]  idx_plus1, best_plus1;
  logic        near_rel, near_lost;
  rdsc_pkg::dec_t decision;
  logic [7:0]  mid_good, mid_idx;
  logic [15:0] mid_bad, mid_sum;
  logic [16:0] exp_sum;
  logic [7:0]  exp_idx;
  logic [7:0]  index_next, calc_index, best_next;
  logic [15:0] calc_delay, best_delay_next;

  always_comb begin
    wa_inc     = window_attempts + 8'd1;
    ws_inc     = window_successes + {7'd0, ok};
    done       = (wa_inc >= cfg.tests_per_window);
    reliable   = (ws_inc >= cfg.success_quota);
    idx_plus1  = {1'b0, current_index} + 9'd1;
    best_plus1 = {1'b0, best_index_reg} + 9'd1;
    near_rel   = (first_failed <= {7'd0, idx_plus1});
    near_lost  = ({1'b0, current_index} <= best_plus1);
  end

  // Judge the window.
  always_comb begin
    priority if (!done) begin
      decision = rdsc_pkg::DEC_NONE;
    end else if (reliable) begin
      priority if (phase_reg == rdsc_pkg::PH_HOLD)         decision = rdsc_pkg::DEC_VERIFIED;
      else if (current_index >= cfg.largest_index)          decision = rdsc_pkg::DEC_HOLD_MIN;
      else if (phase_reg == rdsc_pkg::PH_EXP)               decision = rdsc_pkg::DEC_EXP_LOWER;
      else if (near_rel)                                    decision = rdsc_pkg::DEC_HOLD_BEST;
      else                                                  decision = rdsc_pkg::DEC_BIN_LOWER;
    end else if (phase_reg == rdsc_pkg::PH_EXP) begin
      priority if (!have_reliable)                          decision = rdsc_pkg::DEC_RETRY_MAX;
      else if (near_lost)                                   decision = rdsc_pkg::DEC_HOLD_BEST;
      else                                                  decision = rdsc_pkg::DEC_BIN_START;
    end else if (phase_reg != rdsc_pkg::PH_HOLD) begin
      priority if (near_lost)                               decision = rdsc_pkg::DEC_HOLD_BEST;
      else                                                  decision = rdsc_pkg::DEC_BIN_RAISE;
    end else if (current_index != 8'd0) begin
      decision = rdsc_pkg::DEC_BACKOFF;
    end else begin
      decision = rdsc_pkg::DEC_HOLD_MAX;
    end
  end

  // Next phase.
  always_comb begin
    unique case (decision)
      rdsc_pkg::DEC_HOLD_MIN,
      rdsc_pkg::DEC_HOLD_BEST: phase_next = rdsc_pkg::PH_HOLD;
      rdsc_pkg::DEC_BIN_START: phase_next = rdsc_pkg::PH_BIN;
      default:                 phase_next = phase_reg;
    endcase
  end

  // Bisection between the best good index and the first failed one.
  always_comb begin
    mid_good = reliable ? current_index : best_index_reg;
    mid_bad  = reliable ? first_failed : {8'd0, current_index};
    mid_sum  = {8'd0, mid_good} + ((mid_bad - {8'd0, mid_good}) >> 1);
    mid_idx  = (mid_sum > 16'd255) ? 8'hFF : mid_sum[7:0];
    exp_sum  = {9'd0, current_index} + {1'b0, jump_step};
    exp_idx  = (exp_sum > {9'd0, cfg.largest_index}) ? cfg.largest_index : exp_sum[7:0];
  end

  // Next index and best values.
  always_comb begin
    unique case (decision)
      rdsc_pkg::DEC_EXP_LOWER: index_next = exp_idx;
      rdsc_pkg::DEC_HOLD_BEST: index_next = reliable ? current_index : best_index_reg;
      rdsc_pkg::DEC_BIN_LOWER,
      rdsc_pkg::DEC_BIN_START,
      rdsc_pkg::DEC_BIN_RAISE: index_next = mid_idx;
      rdsc_pkg::DEC_RETRY_MAX: index_next = 8'd0;
      rdsc_pkg::DEC_BACKOFF:   index_next = current_index - 8'd1;
      default:                 index_next = current_index;
    endcase
    calc_index = step ? index_next : current_index;
    if (done && reliable) begin
      best_next       = current_index;
      best_delay_next = cur_delay;
    end else if (decision == rdsc_pkg::DEC_BACKOFF) begin
      best_next       = index_next;
      best_delay_next = calc_delay;
    end else begin
      best_next       = best_index_reg;
      best_delay_next = best_delay_reg;
    end
  end

  rdsc_delay_calc u_delay (
    .cfg      (cfg),
    .index    (calc_index),
    .delay_us (calc_delay)
  );

  always_comb begin
    result.next_index     = index_next;
    result.next_delay_us  = calc_delay;
    result.search_phase   = phase_next;
    result.window_done    = done;
    result.decision       = decision;
    result.found_reliable = have_reliable | (done & reliable);
    result.best_index     = best_next;
    result.best_delay_us  = best_delay_next;
  end

  // Delay of the current index: follows the index and any config change.
  always_ff @(posedge clk) begin
    cur_delay <= calc_delay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= rdsc_pkg::PH_EXP;
      current_index    <= 8'd0;
      window_attempts  <= 8'd0;
      window_successes <= 8'd0;
      have_reliable    <= 1'b0;
      best_index_reg   <= 8'd0;
      best_delay_reg   <= 16'd0;
      first_failed     <= 16'hFFFF;
      jump_step        <= 16'd1;
    end else begin
      if (jump_load) begin
        jump_step <= rdsc_pkg::first_jump(jump_value);
      end
      if (step) begin
        phase_reg      <= phase_next;
        current_index  <= index_next;
        have_reliable  <= result.found_reliable;
        best_index_reg <= best_next;
        best_delay_reg <= best_delay_next;
        if (done) begin
          window_attempts  <= 8'd0;
          window_successes <= 8'd0;
        end else begin
          window_attempts  <= wa_inc;
          window_successes <= ws_inc;
        end
        if (done && !reliable && phase_reg != rdsc_pkg::PH_HOLD) begin
          first_failed <= {8'd0, current_index};
        end
        if (decision == rdsc_pkg::DEC_EXP_LOWER) begin
          if (jump_step <= {1'b0, rdsc_pkg::STEP_DOUBLE_LIMIT}) begin
            jump_step <= {jump_step[14:0], 1'b0};
          end
        end else if (done && !reliable && phase_reg == rdsc_pkg::PH_EXP) begin
          jump_step <= rdsc_pkg::first_jump(cfg.initial_jump);
        end
      end
    end
  end

endmodule

// ----- sv/reply_delay_search_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_delay_search_controller_unit: reply delay calibration search
// Each attempt transaction carries the outcome of one ranging exchange; each
// result transaction gives the delay index and delay to use next, the search
// phase, whether a judging window closed, a decision code and the best
// reliable index and delay found so far.
// Usage:
//  - attempt channel: attempt_valid / attempt_ready, payload attempt_ok.
//  - result channel: result_valid / result_ready, one result per attempt.
//  - cfg_wr_en / cfg_index / cfg_data write the seven search registers;
//    write them only while no attempt is in flight. Index 7 is ignored.
//    Writing initial_jump also reloads the exponential step.
//  - An accepted attempt waits in the attempt register; the search state is
//    then updated and its result loaded into the result register, one
//    attempt per cycle while the result register is free or draining.
//  - Reset (rst, synchronous) restores the register defaults, starts the
//    search in the exponential phase at index zero and empties both stages.
//  - A stalled receiver holds the result; one more attempt is taken into the
//    attempt register, then attempt_ready drops until the result moves.
// ----------------------------------------------------------------------------
module reply_delay_search_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        attempt_valid,
  output logic        attempt_ready,
  input  logic        attempt_ok,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  next_index,
  output logic [15:0] next_delay_us,
  output logic [1:0]  search_phase,
  output logic        window_done,
  output logic [3:0]  decision,
  output logic        found_reliable,
  output logic [7:0]  best_index,
  output logic [15:0] best_delay_us
);

  rdsc_pkg::cfg_t    cfg;
  rdsc_pkg::result_t core_result;
  rdsc_pkg::result_t result_reg;
  logic              hold_full;
  logic              hold_ok;
  logic              advance;
  logic              jump_load;

  // Configuration registers.
  assign jump_load = cfg_wr_en && (cfg_index == rdsc_pkg::REG_JUMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.longest_delay_us  <= 16'd1000;
      cfg.shortest_delay_us <= 16'd1000;
      cfg.delay_step_us     <= 16'd1;
      cfg.largest_index     <= 8'd0;
      cfg.initial_jump      <= 16'd1;
      cfg.tests_per_window  <= 8'd10;
      cfg.success_quota     <= 8'd9;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rdsc_pkg::REG_LONGEST:  cfg.longest_delay_us  <= cfg_data;
        rdsc_pkg::REG_SHORTEST: cfg.shortest_delay_us <= cfg_data;
        rdsc_pkg::REG_STEP:     cfg.delay_step_us     <= cfg_data;
        rdsc_pkg::REG_LARGEST:  cfg.largest_index     <= cfg_data[7:0];
        rdsc_pkg::REG_JUMP:     cfg.initial_jump      <= cfg_data;
        rdsc_pkg::REG_TESTS:    cfg.tests_per_window  <= cfg_data[7:0];
        rdsc_pkg::REG_REQUIRED: cfg.success_quota     <= cfg_data[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Advance the held attempt whenever the result register is free or draining.
  assign advance       = hold_full && (!result_valid || result_ready);
  assign attempt_ready = !hold_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (attempt_ready) begin
      hold_full <= attempt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (attempt_valid && attempt_ready) begin
      hold_ok <= attempt_ok;
    end
  end

  rdsc_search_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .jump_load  (jump_load),
    .jump_value (cfg_data),
    .step       (advance),
    .ok         (hold_ok),
    .result     (core_result)
  );

  // Result register: load on advance, clear once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= core_result;
    end
  end

  assign next_index     = result_reg.next_index;
  assign next_delay_us  = result_reg.next_delay_us;
  assign search_phase   = result_reg.search_phase;
  assign window_done    = result_reg.window_done;
  assign decision       = result_reg.decision;
  assign found_reliable = result_reg.found_reliable;
  assign best_index     = result_reg.best_index;
  assign best_delay_us  = result_reg.best_delay_us;

  // A moved attempt always lands in the result register.
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced attempt did not produce a result");

  // A held attempt that cannot move stays held.
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (hold_full && !advance) |=> hold_full)
    else $error("held attempt lost while result stalled");

  // The decision code agrees with the window flag.
  a_done_decision: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (window_done == (decision != rdsc_pkg::DEC_NONE)))
    else $error("window flag and decision code disagree");

  // The unused phase code is never reported.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (search_phase != 2'd3))
    else $error("search phase out of range");

endmodule

// ----- dv/tb_reply_delay_search_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reply_delay_search_controller_unit: self-checking bench for the search
// Feeds attempt outcomes through a bursty valid/ready driver and checks every
// result transaction, field by field, against an in-bench model of the
// exponential, binary and hold search. Settings are rewritten between phases,
// and the result channel stalls on random and long patterns.
// ----------------------------------------------------------------------------
module tb_reply_delay_search_controller_unit;

  // Slowest legal run: about 1700 attempts, each behind a random sender gap and
  // a receiver that may take one result in four, plus the long hold-offs and
  // settings traffic.
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Receiver stall patterns.
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_MOSTLY = 3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        attempt_valid = 1'b0;
  logic        attempt_ready;
  logic        attempt_ok = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  next_index;
  logic [15:0] next_delay_us;
  logic [1:0]  search_phase;
  logic        window_done;
  logic [3:0]  decision;
  logic        found_reliable;
  logic [7:0]  best_index;
  logic [15:0] best_delay_us;

  reply_delay_search_controller_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .attempt_valid  (attempt_valid),
    .attempt_ready  (attempt_ready),
    .attempt_ok     (attempt_ok),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .next_index     (next_index),
    .next_delay_us  (next_delay_us),
    .search_phase   (search_phase),
    .window_done    (window_done),
    .decision       (decision),
    .found_reliable (found_reliable),
    .best_index     (best_index),
    .best_delay_us  (best_delay_us)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Search model: settings and state, mirrored from the block's reset values
  // --------------------------------------------------------------------------
  logic [15:0] cfg_longest  = 16'd1000;
  logic [15:0] cfg_shortest = 16'd1000;
  logic [15:0] cfg_step     = 16'd1;
  logic [7:0]  cfg_largest  = 8'd0;
  logic [15:0] cfg_jump     = 16'd1;
  logic [7:0]  cfg_tests    = 8'd10;
  logic [7:0]  cfg_required = 8'd9;

  rdsc_pkg::phase_t sm_phase  = rdsc_pkg::PH_EXP;
  logic [7:0]  sm_index       = 8'd0;
  logic [7:0]  sm_attempts    = 8'd0;
  logic [7:0]  sm_successes   = 8'd0;
  logic        sm_have        = 1'b0;
  logic [7:0]  sm_best_idx    = 8'd0;
  logic [15:0] sm_best_delay  = 16'd0;
  logic [15:0] sm_first_fail  = 16'hFFFF;
  logic [15:0] sm_probe       = 16'd1;

  // Attempt outcomes waiting to be driven, and search updates still owed.
  logic              queued_outcomes[$];
  rdsc_pkg::result_t search_updates_due[$];
  rdsc_pkg::result_t due;

  int unsigned outcomes_issued = 0;
  int unsigned updates_seen    = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;

  // Delay of an index: clamp to the largest index, subtract, floor at zero,
  // then raise to the shortest delay.
  function automatic logic [15:0] delay_for_index(input logic [7:0] idx);
    int unsigned clamped;
    int unsigned cut;
    int unsigned d;
    clamped = (idx < cfg_largest) ? idx : cfg_largest;
    cut = clamped * int'(cfg_step);
    d = (cut > cfg_longest) ? 0 : int'(cfg_longest) - cut;
    if (d < cfg_shortest) d = cfg_shortest;
    return d[15:0];
  endfunction

  // Bisect between the best reliable index and the first failed one; always
  // move off the good end when there is room, and clamp to the index range.
  function automatic logic [7:0] bisect_index(input logic [7:0] good,
                                              input logic [15:0] bad);
    int unsigned g;
    int unsigned b;
    int unsigned c;
    g = good;
    b = bad;
    c = g + (b - g) / 2;
    if (c <= g && b > g + 1) c = g + 1;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  function automatic void load_search_reg(input logic [2:0] idx,
                                          input logic [15:0] data);
    case (idx)
      rdsc_pkg::REG_LONGEST:  cfg_longest  = data;
      rdsc_pkg::REG_SHORTEST: cfg_shortest = data;
      rdsc_pkg::REG_STEP:     cfg_step     = data;
      rdsc_pkg::REG_LARGEST:  cfg_largest  = data[7:0];
      rdsc_pkg::REG_JUMP: begin
        // A new jump also restarts the exponential step.
        cfg_jump = data;
        sm_probe = (data == 16'd0) ? 16'd1 : data;
      end
      rdsc_pkg::REG_TESTS:    cfg_tests    = data[7:0];
      rdsc_pkg::REG_REQUIRED: cfg_required = data[7:0];
      default: ;
    endcase
  endfunction

  // Take one attempt outcome and return the update the block should report.
  function automatic rdsc_pkg::result_t advance_search(input logic ok);
    rdsc_pkg::result_t r;
    logic [7:0]        idx;
    int unsigned       nxt;
    int unsigned       sum;
    rdsc_pkg::dec_t    dec;
    logic              closed;
    idx = sm_index;
    nxt = idx;
    dec = rdsc_pkg::DEC_NONE;
    closed = 1'b0;
    sm_attempts = sm_attempts + 8'd1;
    if (ok) sm_successes = sm_successes + 8'd1;
    if (sm_attempts >= cfg_tests) begin
      closed = 1'b1;
      if (sm_successes >= cfg_required) begin
        sm_have = 1'b1;
        sm_best_idx = idx;
        sm_best_delay = delay_for_index(idx);
        if (sm_phase == rdsc_pkg::PH_HOLD) begin
          dec = rdsc_pkg::DEC_VERIFIED;
        end else if (idx >= cfg_largest) begin
          sm_phase = rdsc_pkg::PH_HOLD;
          dec = rdsc_pkg::DEC_HOLD_MIN;
        end else if (sm_phase == rdsc_pkg::PH_EXP) begin
          sum = int'(idx) + int'(sm_probe);
          nxt = (sum > cfg_largest) ? cfg_largest : sum;
          if (sm_probe <= rdsc_pkg::STEP_DOUBLE_LIMIT) sm_probe = sm_probe << 1;
          dec = rdsc_pkg::DEC_EXP_LOWER;
        end else if (sm_first_fail <= int'(sm_best_idx) + 1) begin
          sm_phase = rdsc_pkg::PH_HOLD;
          nxt = sm_best_idx;
          dec = rdsc_pkg::DEC_HOLD_BEST;
        end else begin
          nxt = bisect_index(sm_best_idx, sm_first_fail);
          dec = rdsc_pkg::DEC_BIN_LOWER;
        end
      end else if (sm_phase == rdsc_pkg::PH_EXP) begin
        sm_first_fail = idx;
        sm_probe = (cfg_jump == 16'd0) ? 16'd1 : cfg_jump;
        if (!sm_have) begin
          nxt = 0;
          dec = rdsc_pkg::DEC_RETRY_MAX;
        end else if (sm_first_fail <= int'(sm_best_idx) + 1) begin
          sm_phase = rdsc_pkg::PH_HOLD;
          nxt = sm_best_idx;
          dec = rdsc_pkg::DEC_HOLD_BEST;
        end else begin
          sm_phase = rdsc_pkg::PH_BIN;
          nxt = bisect_index(sm_best_idx, sm_first_fail);
          dec = rdsc_pkg::DEC_BIN_START;
        end
      end else if (sm_phase != rdsc_pkg::PH_HOLD) begin
        sm_first_fail = idx;
        if (sm_first_fail <= int'(sm_best_idx) + 1) begin
          sm_phase = rdsc_pkg::PH_HOLD;
          nxt = sm_best_idx;
          dec = rdsc_pkg::DEC_HOLD_BEST;
        end else begin
          nxt = bisect_index(sm_best_idx, sm_first_fail);
          dec = rdsc_pkg::DEC_BIN_RAISE;
        end
      end else if (idx > 0) begin
        // Failing while holding: back off one index and take it as best.
        nxt = idx - 1;
        sm_best_idx = nxt[7:0];
        sm_best_delay = delay_for_index(nxt[7:0]);
        dec = rdsc_pkg::DEC_BACKOFF;
      end else begin
        dec = rdsc_pkg::DEC_HOLD_MAX;
      end
      sm_index = nxt[7:0];
      sm_attempts = 8'd0;
      sm_successes = 8'd0;
    end
    r.next_index     = sm_index;
    r.next_delay_us  = delay_for_index(sm_index);
    r.search_phase   = sm_phase;
    r.window_done    = closed;
    r.decision       = dec;
    r.found_reliable = sm_have;
    r.best_index     = sm_best_idx;
    r.best_delay_us  = sm_best_delay;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Attempt driver: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      attempt_valid <= 1'b0;
    end else begin
      // Model the accepted transaction before anything new is offered.
      if (attempt_valid && attempt_ready)
        search_updates_due.push_back(advance_search(attempt_ok));
      // Hold valid and payload while a transaction is still waiting.
      if (!attempt_valid || attempt_ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          attempt_valid <= 1'b0;
        end else if (queued_outcomes.size() != 0) begin
          attempt_valid <= 1'b1;
          attempt_ok <= queued_outcomes.pop_front();
          if (burst_left != 0) begin
            burst_left = burst_left - 1;
          end else begin
            // Close the burst; a quarter of them run straight into the next.
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          attempt_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: rolling stall patterns, plus a long hold-off now and then
  // so that both pipeline stages fill and attempt_ready drops
  // --------------------------------------------------------------------------
  int unsigned rx_taken    = 0;
  int unsigned rx_hold     = 0;
  int unsigned rx_mode_len = 0;
  int          rx_mode     = RX_OPEN;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        rx_taken = rx_taken + 1;
        if (rx_taken % 400 == 150) rx_hold = 90;
      end
      if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
        result_ready <= 1'b0;
      end else begin
        if (rx_mode_len == 0) begin
          rx_mode = $urandom_range(RX_OPEN, RX_MOSTLY);
          rx_mode_len = $urandom_range(20, 100);
        end else begin
          rx_mode_len = rx_mode_len - 1;
        end
        case (rx_mode)
          RX_OPEN:   result_ready <= 1'b1;
          RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: result_ready <= (rx_mode_len % 4 == 0);
          default:   result_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted transaction with the oldest update
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      updates_seen++;
      if (search_updates_due.size() == 0) begin
        $error("result transaction with no attempt outstanding (next_index %0d)",
               next_index);
        mismatch_count++;
      end else begin
        due = search_updates_due.pop_front();
        compare_field("next_index",     due.next_index,     next_index);
        compare_field("next_delay_us",  due.next_delay_us,  next_delay_us);
        compare_field("search_phase",   due.search_phase,   search_phase);
        compare_field("window_done",    due.window_done,    window_done);
        compare_field("decision",       due.decision,       decision);
        compare_field("found_reliable", due.found_reliable, found_reliable);
        compare_field("best_index",     due.best_index,     best_index);
        compare_field("best_delay_us",  due.best_delay_us,  best_delay_us);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_attempt(input logic ok);
    queued_outcomes.push_back(ok);
    outcomes_issued++;
  endtask

  // Push the low count bits of a pattern, most significant first.
  task automatic push_pattern(input logic [15:0] bits, input int count);
    for (int i = count - 1; i >= 0; i--) push_attempt(bits[i]);
  endtask

  // Wait until every attempt issued has come back, then let the pipeline
  // settle before touching the settings.
  task automatic wait_idle();
    while (updates_seen != outcomes_issued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    load_search_reg(idx, data);
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Settings for a random phase: phase one takes every register to zero,
  // phase two to all ones; otherwise mostly small windows and useful delays.
  function automatic logic [15:0] pick_setting(input logic [2:0] reg_idx,
                                               input int phase_no);
    logic [15:0] v;
    v = 16'($urandom());
    if (phase_no == 1) begin
      v = 16'h0000;
    end else if (phase_no == 2) begin
      v = 16'hFFFF;
    end else begin
      case (reg_idx)
        rdsc_pkg::REG_TESTS:    v[7:0] = 8'($urandom_range(0, 12));
        rdsc_pkg::REG_REQUIRED: v[7:0] = 8'($urandom_range(0, 12));
        rdsc_pkg::REG_LONGEST:
          if ($urandom_range(0, 2) != 0) v = 16'($urandom_range(0, 5000));
        rdsc_pkg::REG_SHORTEST:
          if ($urandom_range(0, 2) != 0) v = 16'($urandom_range(0, 1000));
        rdsc_pkg::REG_STEP:
          if ($urandom_range(0, 2) != 0) v = 16'($urandom_range(0, 300));
        rdsc_pkg::REG_JUMP:
          if ($urandom_range(0, 2) != 0) v = 16'($urandom_range(0, 20));
        default: ;
      endcase
    end
    return v;
  endfunction

  initial begin
    int          quota;
    int          sent;
    int          pass_pct;
    int          span;
    int          ones;
    int          slots;
    int          lo;
    logic        bit_ok;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: one attempt per window, full index range, a step so
    // large that every non-zero index drops to zero delay, and a zero jump.
    write_cfg(rdsc_pkg::REG_LONGEST, 16'hFFFF);
    write_cfg(rdsc_pkg::REG_SHORTEST, 16'h0000);
    write_cfg(rdsc_pkg::REG_STEP, 16'hFFFF);
    write_cfg(rdsc_pkg::REG_LARGEST, 16'h00FF);
    write_cfg(rdsc_pkg::REG_JUMP, 16'h0000);
    write_cfg(rdsc_pkg::REG_TESTS, 16'h0001);
    write_cfg(rdsc_pkg::REG_REQUIRED, 16'h0001);
    end_cfg();
    // Fail with nothing reliable, then climb by a doubling step.
    push_pattern(16'b01111, 5);
    wait_idle();
    // Reload the step near its doubling limit; the next probe clamps at the
    // largest index, then failures open and narrow the bisection, settle
    // into hold, verify and back off.
    write_cfg(rdsc_pkg::REG_JUMP, 16'h7FFF);
    end_cfg();
    push_pattern(16'b10010100010, 11);

    // Random phases: mostly well-formed windows with a phase-wide success
    // bias, salted with stray attempts that knock the windows out of step.
    for (int ph = 0; ph < 13; ph++) begin
      wait_idle();
      for (int r = 0; r < 8; r++) begin
        if (ph < 3 || $urandom_range(0, 2) != 0)
          write_cfg(3'(r), pick_setting(3'(r), ph));
      end
      end_cfg();
      quota = (ph == 2) ? 510 : 95;
      pass_pct = $urandom_range(20, 80);
      sent = 0;
      while (sent < quota) begin
        if ($urandom_range(0, 99) < 15) begin
          push_attempt($urandom_range(0, 1));
          sent++;
        end else begin
          span = (cfg_tests == 0) ? 1 : cfg_tests;
          lo = (cfg_required > span) ? span : cfg_required;
          if ($urandom_range(0, 99) < pass_pct || cfg_required == 0)
            ones = $urandom_range(lo, span);
          else
            ones = $urandom_range(0, (cfg_required - 1 > span) ? span
                                                               : cfg_required - 1);
          // Scatter exactly that many successes over the window.
          slots = span;
          while (slots != 0) begin
            bit_ok = (ones != 0) && ($urandom_range(1, slots) <= ones);
            if (bit_ok) ones--;
            push_attempt(bit_ok);
            slots--;
          end
          sent += span;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rdsc_pkg.sv
sv/rdsc_delay_calc.sv
sv/rdsc_search_core.sv
sv/reply_delay_search_controller_unit.sv
dv/tb_reply_delay_search_controller_unit.sv
